### rtl/ucm_pkg.sv
// Package for the underrun noise crossfade mixer: state codes, constants and shared types.
package ucm_pkg;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_TGT,
    ST_SMOOTH,
    ST_GAIN,
    ST_MIX_S,
    ST_MIX_N,
    ST_ACC,
    ST_VOL_LO,
    ST_VOL_HI,
    ST_SUM,
    ST_DONE
  } ucm_state_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME     = 2'd2;

  // Register reset values.
  localparam logic [15:0] FADE_RESET  = 16'd16384;
  localparam logic [15:0] ALPHA_RESET = 16'd52;
  localparam logic [15:0] VOL_RESET   = 16'd32768;

  // Gain is Q1.30 and never leaves 0..1, so 31 bits hold it.
  localparam int unsigned GAIN_W = 31;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 31'h4000_0000;

  localparam logic [31:0] RNG_SEED = 32'h0000_ACE1;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Divider: 30 quotient bits, three bits retired per cycle.
  localparam int unsigned QUO_W     = 30;
  localparam int unsigned DIV_BITS  = 3;
  localparam int unsigned DIV_STEPS = QUO_W / DIV_BITS;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/ucm_div.sv
// Iterative restoring divider giving floor(dividend * 2^30 / divisor) for dividend < divisor.
module ucm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [15:0]                dividend,
  input  logic [15:0]                divisor,
  output ucm_pkg::div_stat_t         stat,
  output logic [ucm_pkg::QUO_W-1:0]  quotient
);
  import ucm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic [16:0]         rem_r, rem_nxt;
  logic [QUO_W-1:0]    quo_r;
  logic [DIV_BITS-1:0] bits_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r, done_r;

  // Several compare-and-subtract steps on the narrow remainder per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    bits_nxt = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_nxt = {rem_nxt[15:0], 1'b0};
      if (rem_nxt >= {1'b0, divisor}) begin
        rem_nxt = rem_nxt - {1'b0, divisor};
        bits_nxt[DIV_BITS-1-i] = 1'b1;
      end
    end
  end

  // Control: busy for a fixed number of steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUO_W-DIV_BITS-1:0], bits_nxt};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

### rtl/ucm_mul.sv
// Shared signed multiplier with a registered product.
module ucm_mul (
  input  logic                                clk,
  input  logic signed [ucm_pkg::MUL_A_W-1:0]  op_a,
  input  logic signed [ucm_pkg::MUL_B_W-1:0]  op_b,
  output logic signed [ucm_pkg::MUL_P_W-1:0]  prod
);
  import ucm_pkg::*;

  logic signed [MUL_P_W-1:0] prod_r;

  // One multiply per cycle; the product is taken up in the next state.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

### rtl/underrun_noise_crossfade_mixer_top.sv
// Top level of the underrun noise crossfade mixer: sequencer, state and datapath.
//
//  Channel | Direction | Handshake             | Word
//  in      | input     | in_valid / in_ready   | in_sample, in_fill_level
//  out     | output    | out_valid / out_ready | out_sample, out_clipped
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// An accepted sample first runs through the target-gain divider, three
// quotient bits a cycle; the smoothing, mixing and volume steps then use the one
// shared multiplier. A new sample is taken only once the sequencer is idle
// again. Reset is synchronous and active low and needs no clearing pass.
// A stalled output holds the finished word while the block goes idle;
// a further word then waits in the final state until the output register frees.
module underrun_noise_crossfade_mixer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               in_sample,
  input  logic [15:0]                      in_fill_level,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               out_sample,
  output logic                             out_clipped,
  input  logic                             cfg_we,
  input  logic [ucm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);
  import ucm_pkg::*;

  localparam logic signed [62:0] ROUND_BIAS = 63'sh1FFF_FFFF_FFFF;

  ucm_state_t state_r, state_nxt;

  logic [15:0]               fade_r, alpha_r, vol_r;
  logic [31:0]               rng_r, rng_a, rng_b, rng_c;
  logic signed [15:0]        lp_r, white;
  logic signed [16:0]        lp_diff, lp_step, lp_sum;
  logic [GAIN_W-1:0]         g_r, g_nxt, target;
  logic signed [32:0]        g_sum;
  logic                      fill_ge_r;
  logic signed [15:0]        sample_r;
  logic signed [31:0]        diff_r, diff_nxt;
  logic signed [46:0]        acc_r;
  logic [47:0]               lo_r;
  logic signed [62:0]        prod_r, rounded;
  logic signed [17:0]        quo;
  logic                      accept, out_free, sat_hi, sat_lo;
  logic                      out_valid_r, out_clipped_r;
  logic signed [15:0]        out_sample_r;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [QUO_W-1:0]          quotient;
  div_stat_t                 div_stat;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r  <= FADE_RESET;
      alpha_r <= ALPHA_RESET;
      vol_r   <= VOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FADE_START: fade_r  <= cfg_data;
        CFG_ALPHA:      alpha_r <= cfg_data;
        CFG_VOLUME:     vol_r   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Target gain divider.
  ucm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (in_fill_level),
    .divisor  (fade_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Shared multiplier.
  ucm_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DIV;
      ST_DIV:    if (div_stat.done) state_nxt = ST_TGT;
      ST_TGT:    state_nxt = ST_SMOOTH;
      ST_SMOOTH: state_nxt = ST_GAIN;
      ST_GAIN:   state_nxt = ST_MIX_S;
      ST_MIX_S:  state_nxt = ST_MIX_N;
      ST_MIX_N:  state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_VOL_LO;
      ST_VOL_LO: state_nxt = ST_VOL_HI;
      ST_VOL_HI: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer outputs: input ready and multiplier operand selection.
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      ST_SMOOTH: begin
        mul_a = {diff_r[31], diff_r};
        mul_b = {2'b00, alpha_r};
      end
      ST_MIX_S: begin
        mul_a = {2'b00, GAIN_ONE - g_r};
        mul_b = {{2{sample_r[15]}}, sample_r};
      end
      ST_MIX_N: begin
        mul_a = {2'b00, g_r};
        mul_b = {{2{lp_r[15]}}, lp_r};
      end
      ST_VOL_LO: begin
        mul_a = {1'b0, acc_r[31:0]};
        mul_b = {2'b00, vol_r};
      end
      ST_VOL_HI: begin
        mul_a = {{18{acc_r[46]}}, acc_r[46:32]};
        mul_b = {2'b00, vol_r};
      end
      default: ;
    endcase
  end

  // Xorshift generator and the shift-by-three lowpass on its low half.
  always_comb begin
    rng_a   = rng_r ^ (rng_r << 13);
    rng_b   = rng_a ^ (rng_a >> 17);
    rng_c   = rng_b ^ (rng_b << 5);
    white   = $signed(rng_c[15:0]);
    lp_diff = {white[15], white} - {lp_r[15], lp_r};
    lp_step = lp_diff >>> 3;
    lp_sum  = {lp_r[15], lp_r} + lp_step;
  end

  // Target gain, its distance from the smoothed gain, and the smoothing step.
  always_comb begin
    target   = fill_ge_r ? '0 : GAIN_ONE - {1'b0, quotient};
    diff_nxt = $signed({1'b0, target}) - $signed({1'b0, g_r});
    g_sum    = $signed({2'b00, g_r}) + mul_p[48:16];
    g_nxt    = g_sum[GAIN_W-1:0];
  end

  // Scale down by 2^45 rounding toward zero, then saturate.
  always_comb begin
    rounded = prod_r[62] ? prod_r + ROUND_BIAS : prod_r;
    quo     = rounded[62:45];
    sat_hi  = quo > 18'sd32767;
    sat_lo  = quo < -18'sd32768;
  end

  // State carried from sample to sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r <= RNG_SEED;
      lp_r  <= '0;
      g_r   <= '0;
    end else begin
      if (accept) begin
        rng_r <= rng_c;
        lp_r  <= lp_sum[15:0];
      end
      if (state_r == ST_GAIN) begin
        g_r <= g_nxt;
      end
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r  <= in_sample;
      fill_ge_r <= (in_fill_level >= fade_r);
    end
    case (state_r)
      ST_TGT:    diff_r <= diff_nxt;
      ST_MIX_N:  acc_r  <= mul_p[46:0];
      ST_ACC:    acc_r  <= acc_r + mul_p[46:0];
      ST_VOL_HI: lo_r   <= mul_p[47:0];
      ST_SUM:    prod_r <= {mul_p[30:0], 32'b0} + {15'b0, lo_r};
      default:   ;
    endcase
  end

  // Output register, which frees the sequencer while a word waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_clipped_r <= sat_hi || sat_lo;
      if (sat_hi) begin
        out_sample_r <= 16'sh7FFF;
      end else if (sat_lo) begin
        out_sample_r <= -16'sh8000;
      end else begin
        out_sample_r <= quo[15:0];
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_clipped = out_clipped_r;

  // An accepted word starts the divider and the division state.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_DIV) && div_stat.busy)
    else $error("accepted word did not start the division");

  // The divider is never running while the sequencer is idle.
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the division state");

  // The smoothed gain stays within zero to one.
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    g_r <= GAIN_ONE)
    else $error("smoothed gain above unity");

  // Leaving the final state always presents a word.
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_free |=> out_valid)
    else $error("finished word not presented");

endmodule

### tb/tb_top.sv
// Testbench for the underrun noise crossfade mixer: directed table, random phases, predicted words.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index that no register answers to; writes to it must be ignored.
  localparam logic [ucm_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;

  localparam int unsigned RAND_ITEMS  = 650;
  localparam int unsigned HOLD_OFF    = 4;
  localparam int unsigned END_WAIT    = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NROWS       = 31;

  localparam longint GAIN_UNIT = longint'(ucm_pkg::GAIN_ONE);
  localparam longint MIX_SCALE = 64'sd1 <<< 45;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [ucm_pkg::CFG_IDX_W-1:0] idx;
    logic [15:0] data;
    logic [15:0] smp;
    logic [15:0] fill;
    logic        known;
    logic [15:0] want_smp;
    logic        want_clip;
  } plan_row_t;

  typedef struct packed {
    logic [15:0] smp;
    logic        clip;
  } mix_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_sample = '0;
  logic [15:0] in_fill_level = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_sample;
  logic out_clipped;
  logic cfg_we = 1'b0;
  logic [ucm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predictor copy of the registers and the block state.
  logic [15:0] fade_q;
  logic [15:0] alpha_q;
  logic [15:0] vol_q;
  logic [31:0] rng_q;
  int          noise_lp;
  longint      gain_q30;

  mix_word_t   mix_expect_q [$];
  mix_word_t   mon_want;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned rcv_left = 0;
  logic        rcv_take;

  plan_row_t plan [NROWS];

  underrun_noise_crossfade_mixer_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_fill_level (in_fill_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample    (out_sample),
    .out_clipped   (out_clipped),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advances the predictor by one sample and returns the mixed word it should produce.
  function automatic mix_word_t predict_mix(input logic [15:0] smp, input logic [15:0] fill);
    longint    tgt;
    longint    acc;
    longint    q;
    logic [31:0] x;
    int        white;
    int        s;
    mix_word_t r;
    // Target gain: zero at or above the fade start, full at an empty buffer.
    if (fill >= fade_q) begin
      tgt = 0;
    end else if (fill == 16'd0) begin
      tgt = GAIN_UNIT;
    end else begin
      tgt = GAIN_UNIT - ((longint'(fill) <<< 30) / longint'(fade_q));
    end
    gain_q30 = gain_q30 + (((tgt - gain_q30) * longint'(alpha_q)) >>> 16);
    // Xorshift white noise, then the shift-by-three lowpass.
    x = rng_q;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    rng_q = x;
    white = $signed(x[15:0]);
    noise_lp = noise_lp + ((white - noise_lp) >>> 3);
    // Crossfade, volume, truncation toward zero, then saturation.
    s = $signed(smp);
    acc = longint'(s) * (GAIN_UNIT - gain_q30) + longint'(noise_lp) * gain_q30;
    q = (acc * longint'(vol_q)) / MIX_SCALE;
    r.clip = 1'b0;
    if (q > 32767) begin
      q = 32767;
      r.clip = 1'b1;
    end else if (q < -32768) begin
      q = -32768;
      r.clip = 1'b1;
    end
    r.smp = q[15:0];
    return r;
  endfunction

  // Presents one input word and waits for it to be taken; valid is left high.
  task automatic send_word(input logic [15:0] smp, input logic [15:0] fill,
                           input logic known, input mix_word_t typed);
    mix_word_t pred;
    in_valid      <= 1'b1;
    in_sample     <= smp;
    in_fill_level <= fill;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_mix(smp, fill);
    mix_expect_q.push_back(known ? typed : pred);
  endtask

  // Sender gap of a given number of cycles.
  task automatic idle_for(input int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every expected word has come out.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (mix_expect_q.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // One register write, mirrored into the predictor.
  task automatic cfg_write(input logic [ucm_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ucm_pkg::CFG_FADE_START: fade_q = data;
      ucm_pkg::CFG_ALPHA:      alpha_q = data;
      ucm_pkg::CFG_VOLUME:     vol_q = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Receiver: random runs of taking and stalling, mostly taking.
  always @(posedge clk) begin
    if (rcv_left == 0) begin
      rcv_take = ($urandom_range(0, 3) != 0);
      rcv_left = rcv_take ? $urandom_range(1, 40) : $urandom_range(1, 20);
      out_ready <= rcv_take;
    end else begin
      rcv_left = rcv_left - 1;
    end
  end

  // Checks each output word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (mix_expect_q.size() == 0) begin
        $display("%0t: word with no expectation: expected none, got out_sample %0d clipped %0b",
                 $time, out_sample, out_clipped);
        mismatch_cnt++;
      end else begin
        mon_want = mix_expect_q.pop_front();
        if (out_sample !== mon_want.smp) begin
          $display("%0t: out_sample expected %0d, got %0d",
                   $time, $signed(mon_want.smp), out_sample);
          mismatch_cnt++;
        end
        if (out_clipped !== mon_want.clip) begin
          $display("%0t: out_clipped expected %0b, got %0b", $time, mon_want.clip, out_clipped);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] rnd;
    logic [15:0] smp;
    logic [15:0] fill;
    int unsigned rand_sent;
    int unsigned batch;
    int unsigned burst;

    // Directed table. Typed expectations hold while the gain is still zero or the volume is zero.
    plan = '{
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h7FFF, 16'd16384, 1'b1, 16'h7FFF, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h8000, 16'd40000, 1'b1, 16'h8000, 1'b0},
      '{ROW_CFG, ucm_pkg::CFG_VOLUME, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h7FFF, 16'hFFFF, 1'b1, 16'h7FFF, 1'b1},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h8000, 16'hFFFF, 1'b1, 16'h8000, 1'b1},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h0001, 16'hFFFF, 1'b1, 16'h0001, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
      '{ROW_CFG, ucm_pkg::CFG_VOLUME, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h3039, 16'h0000, 1'b1, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h8000, 16'h0000, 1'b1, 16'h0000, 1'b0},
      '{ROW_CFG, ucm_pkg::CFG_VOLUME, 16'h8000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_CFG, ucm_pkg::CFG_ALPHA, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h7FFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h8000, 16'd100, 1'b0, 16'h0000, 1'b0},
      '{ROW_CFG, ucm_pkg::CFG_FADE_START, 16'h0001, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h1234, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'hEDCC, 16'h0001, 1'b0, 16'h0000, 1'b0},
      '{ROW_CFG, ucm_pkg::CFG_FADE_START, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h7FFF, 16'hFFFE, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h8000, 16'h8000, 1'b0, 16'h0000, 1'b0},
      '{ROW_CFG, ucm_pkg::CFG_FADE_START, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h5555, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_CFG, ucm_pkg::CFG_ALPHA, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'hAAAA, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_CFG, CFG_IDX_NONE, 16'h0001, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h0F0F, 16'h0010, 1'b0, 16'h0000, 1'b0},
      '{ROW_CFG, ucm_pkg::CFG_FADE_START, ucm_pkg::FADE_RESET, 16'h0000, 16'h0000, 1'b0,
        16'h0000, 1'b0},
      '{ROW_CFG, ucm_pkg::CFG_ALPHA, ucm_pkg::ALPHA_RESET, 16'h0000, 16'h0000, 1'b0,
        16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h7FFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WORD, CFG_IDX_NONE, 16'h0000, 16'h8000, 16'h0000, 1'b0, 16'h0000, 1'b0}
    };

    // Predictor starts from the reset state.
    fade_q   = ucm_pkg::FADE_RESET;
    alpha_q  = ucm_pkg::ALPHA_RESET;
    vol_q    = ucm_pkg::VOL_RESET;
    rng_q    = ucm_pkg::RNG_SEED;
    noise_lp = 0;
    gain_q30 = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part: registers change only once the block has gone quiet.
    for (int i = 0; i < NROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_block();
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].smp, plan[i].fill, plan[i].known,
                  '{smp: plan[i].want_smp, clip: plan[i].want_clip});
        idle_for($urandom_range(0, 3));
      end
    end

    // Random phases: fresh settings, then bursts of words with gaps between them.
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      drain_block();
      case ($urandom_range(0, 5))
        0:       rnd = 0;
        1:       rnd = 1;
        2:       rnd = 32'hFFFF;
        3:       rnd = $urandom_range(1, 1024);
        default: rnd = $urandom_range(1, 65535);
      endcase
      cfg_write(ucm_pkg::CFG_FADE_START, rnd[15:0]);
      case ($urandom_range(0, 6))
        0:       rnd = 0;
        1:       rnd = 1;
        2:       rnd = 32'hFFFF;
        3:       rnd = ucm_pkg::ALPHA_RESET;
        default: rnd = $urandom_range(256, 65535);
      endcase
      cfg_write(ucm_pkg::CFG_ALPHA, rnd[15:0]);
      case ($urandom_range(0, 5))
        0:       rnd = 0;
        1:       rnd = 32'hFFFF;
        2:       rnd = ucm_pkg::VOL_RESET;
        default: rnd = $urandom;
      endcase
      cfg_write(ucm_pkg::CFG_VOLUME, rnd[15:0]);
      if ($urandom_range(0, 7) == 0) begin
        rnd = $urandom;
        cfg_write(CFG_IDX_NONE, rnd[15:0]);
      end

      batch = $urandom_range(15, 60);
      while (batch > 0 && rand_sent < RAND_ITEMS) begin
        burst = $urandom_range(1, 12);
        while (burst > 0 && batch > 0 && rand_sent < RAND_ITEMS) begin
          case ($urandom_range(0, 9))
            0:       smp = 16'h7FFF;
            1:       smp = 16'h8000;
            2:       smp = 16'h0000;
            default: begin
              rnd = $urandom;
              smp = rnd[15:0];
            end
          endcase
          // Fill mostly around the fade region so the gain keeps moving.
          case ($urandom_range(0, 7))
            0:       rnd = 0;
            1:       rnd = 32'hFFFF;
            2:       rnd = fade_q;
            3:       rnd = fade_q - 16'd1;
            4, 5:    rnd = (fade_q > 16'd1) ? $urandom_range(0, fade_q - 1) : $urandom;
            default: rnd = $urandom;
          endcase
          fill = rnd[15:0];
          send_word(smp, fill, 1'b0, '0);
          burst--;
          batch--;
          rand_sent++;
        end
        case ($urandom_range(0, 11))
          0, 1, 2: ;
          3:       idle_for($urandom_range(15, 30));
          4:       drain_block();
          default: idle_for($urandom_range(1, 6));
        endcase
      end
    end

    drain_block();
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_cnt == 0 && mix_expect_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
